// ===== hdl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_W    = 16;
  localparam int PAY_W    = 16;
  localparam int COUNT_W  = 5;
  localparam int OCC_W    = $clog2(DEPTH + 1);
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;
  localparam int M_USER_W = 3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_POP,
    OP_DROP_FULL,
    OP_POP_EMPTY
  } op_e;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage

// ===== hdl/spq_ctrl.sv =====
// Handshake controller: takes requests, issues queue operations, holds the response slot.
module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          action_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  input  spq_pkg::stat_t stat_i,
  output spq_pkg::cmd_t  cmd_o
);
  import spq_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_RESP;
      end
      S_RESP: begin
        if (accept) state_d = S_RESP;
        else if (m_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: s_ready_o = 1'b1;
      S_RESP: begin
        m_valid_o = 1'b1;
        // slot frees this cycle, so the next request may enter
        s_ready_o = m_ready_i;
      end
      default: s_ready_o = 1'b0;
    endcase
    accept = s_valid_i && s_ready_o;
    cmd_o.op = OP_NONE;
    if (accept) begin
      if (action_i) cmd_o.op = stat_i.empty ? OP_POP_EMPTY : OP_POP;
      else          cmd_o.op = stat_i.full  ? OP_DROP_FULL : OP_INSERT;
    end
  end

endmodule

// ===== hdl/spq_dpath.sv =====
// Datapath: sorted shift-register chain of entries, occupancy counter and response register.
module spq_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spq_pkg::cmd_t               cmd_i,
  input  logic [spq_pkg::KEY_W-1:0]   key_i,
  input  logic [spq_pkg::PAY_W-1:0]   payload_i,
  output spq_pkg::stat_t              stat_o,
  output logic                        res_valid_o,
  output logic [spq_pkg::KEY_W-1:0]   res_key_o,
  output logic [spq_pkg::PAY_W-1:0]   res_payload_o,
  output spq_pkg::status_e            res_status_o,
  output logic [spq_pkg::COUNT_W-1:0] res_count_o
);
  import spq_pkg::*;

  logic [KEY_W-1:0] key_q [DEPTH];
  logic [KEY_W-1:0] key_d [DEPTH];
  logic [PAY_W-1:0] pay_q [DEPTH];
  logic [PAY_W-1:0] pay_d [DEPTH];
  logic [DEPTH-1:0] gt;
  logic [OCC_W-1:0] occ_q, occ_d;

  logic               res_valid_q;
  logic [KEY_W-1:0]   res_key_q;
  logic [PAY_W-1:0]   res_pay_q;
  status_e            res_status_q;
  logic [COUNT_W-1:0] res_count_q;

  assign stat_o.full  = (occ_q == OCC_W'(DEPTH));
  assign stat_o.empty = (occ_q == '0);

  // gt marks held entries whose key is strictly above the new key; monotone in a sorted chain
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (OCC_W'(i) < occ_q) && (key_q[i] > key_i);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      key_d[i] = key_q[i];
      pay_d[i] = pay_q[i];
      if (cmd_i.op == OP_INSERT) begin
        if (gt[i] || (OCC_W'(i) == occ_q)) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            key_d[i] = key_q[(i > 0) ? i - 1 : 0];
            pay_d[i] = pay_q[(i > 0) ? i - 1 : 0];
          end else begin
            key_d[i] = key_i;
            pay_d[i] = payload_i;
          end
        end
      end else if (cmd_i.op == OP_POP) begin
        if (i < DEPTH - 1) begin
          key_d[i] = key_q[(i < DEPTH - 1) ? i + 1 : i];
          pay_d[i] = pay_q[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    occ_d = occ_q;
    case (cmd_i.op)
      OP_INSERT: occ_d = occ_q + OCC_W'(1);
      OP_POP:    occ_d = occ_q - OCC_W'(1);
      default:   occ_d = occ_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      key_q[i] <= key_d[i];
      pay_q[i] <= pay_d[i];
    end
    if (cmd_i.op != OP_NONE) begin
      res_valid_q <= (cmd_i.op == OP_POP);
      res_key_q   <= (cmd_i.op == OP_POP) ? key_q[0] : '0;
      res_pay_q   <= (cmd_i.op == OP_POP) ? pay_q[0] : '0;
      res_count_q <= COUNT_W'(occ_d);
      case (cmd_i.op)
        OP_DROP_FULL: res_status_q <= ST_FULL;
        OP_POP_EMPTY: res_status_q <= ST_EMPTY;
        default:      res_status_q <= ST_OK;
      endcase
    end
  end

  assign res_valid_o   = res_valid_q;
  assign res_key_o     = res_key_q;
  assign res_payload_o = res_pay_q;
  assign res_status_o  = res_status_q;
  assign res_count_o   = res_count_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_INSERT |=> occ_q == $past(occ_q) + OCC_W'(1))
    else $error("insert did not grow occupancy");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_POP |=> occ_q == $past(occ_q) - OCC_W'(1))
    else $error("pop did not shrink occupancy");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q >= OCC_W'(2) |-> key_q[0] <= key_q[1])
    else $error("head entries out of order");

  a_pop_returns_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_POP |=> res_valid_q && res_key_q == $past(key_q[0]))
    else $error("pop result is not the smallest entry");

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Sorted priority queue top level: stream ports, controller and datapath.
//
// Holds up to 16 entries (key, payload) sorted by ascending key; equal keys
// leave in arrival order.
// Input stream: s_axis_tuser = action (0 insert, 1 dequeue), s_axis_tdata
// = {payload, key}. Every request yields exactly one response on the
// output stream: tuser = {status, out_valid}, tdata = {count, payload, key}.
// Status 0 ok, 1 insert dropped because full, 2 dequeue on empty.
// The response is registered and appears in the cycle after the request is taken.
// Throughput: one request per cycle while the receiver keeps tready high;
// the whole insert or dequeue is a single shift of the entry chain, with
// every entry compared against the new key in parallel.
// The response waits in an output register; with the receiver stalled one
// response is held and no further request is taken until it leaves.
// Reset (rst_ni low, asynchronous) empties the queue and drops any pending
// response.
module sorted_priority_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [spq_pkg::S_DATA_W-1:0]    s_axis_tdata,  // [15:0] key, [31:16] payload
  input  logic                            s_axis_tuser,  // [0] action
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [spq_pkg::M_DATA_W-1:0]    m_axis_tdata,  // [15:0] out_key, [31:16] out_payload,
                                                         // [36:32] count, rest zero
  output logic [spq_pkg::M_USER_W-1:0]    m_axis_tuser   // [0] out_valid, [2:1] status
);
  import spq_pkg::*;

  cmd_t               cmd;
  stat_t              stat;
  logic               res_valid;
  logic [KEY_W-1:0]   res_key;
  logic [PAY_W-1:0]   res_pay;
  status_e            res_status;
  logic [COUNT_W-1:0] res_count;

  spq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .action_i  (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  spq_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .key_i         (s_axis_tdata[KEY_W-1:0]),
    .payload_i     (s_axis_tdata[KEY_W+PAY_W-1:KEY_W]),
    .stat_o        (stat),
    .res_valid_o   (res_valid),
    .res_key_o     (res_key),
    .res_payload_o (res_pay),
    .res_status_o  (res_status),
    .res_count_o   (res_count)
  );

  assign m_axis_tdata = {(M_DATA_W - KEY_W - PAY_W - COUNT_W)'(0), res_count, res_pay, res_key};
  assign m_axis_tuser = {res_status, res_valid};

endmodule
